@@ hdl/seeded_perlin_octave_noise_unit_assert.svh @@
// Assertion macros shared by the noise unit modules
`ifndef SEEDED_PERLIN_OCTAVE_NOISE_UNIT_ASSERT_SVH
`define SEEDED_PERLIN_OCTAVE_NOISE_UNIT_ASSERT_SVH

// condition holds in the same cycle
`define SPON_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the next cycle
`define SPON_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/spon_pkg.sv @@
// Shared types and constants of the seeded Perlin octave noise unit
package spon_pkg;

    localparam int TABLE_SIZE   = 256;
    localparam int TAB_AW       = $clog2(TABLE_SIZE);
    localparam int IDX_W        = TAB_AW + 1;
    localparam int OCT_W        = 5;
    localparam int MAX_OCTAVES_DEF     = 8;
    localparam int COORD_FRAC_BITS_DEF = 16;

    localparam logic [31:0] LCG_MUL = 32'd1664525;
    localparam logic [31:0] LCG_INC = 32'd1013904223;
    localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

    localparam logic [31:0] SEED_RST = 32'd0;
    localparam logic [1:0]  DIMS_RST = 2'd2;
    localparam logic [3:0]  OCTC_RST = 4'd4;
    localparam logic [16:0] PERS_RST = 17'd32768;
    localparam logic [15:0] LAC_RST  = 16'd512;

    typedef enum logic [2:0] {
        CFG_SEED = 3'd0,
        CFG_DIMS = 3'd1,
        CFG_OCTC = 3'd2,
        CFG_PERS = 3'd3,
        CFG_LAC  = 3'd4
    } t_cfg;

    typedef enum logic [5:0] {
        ST_IDLE, ST_R_INIT, ST_R_LCG, ST_R_DLOAD, ST_R_DIV,
        ST_R_RDI, ST_R_RDJ, ST_R_WRI, ST_R_WRJ,
        ST_S_MX, ST_S_MY, ST_S_FX1, ST_S_FX2, ST_S_FX3,
        ST_S_FY1, ST_S_FY2, ST_S_FY3,
        ST_S_RA, ST_S_RB, ST_S_RAA, ST_S_RBA, ST_S_RAB, ST_S_RBB, ST_S_LAT,
        ST_S_BL1D, ST_S_BLR0, ST_S_BLR1, ST_S_BLN, ST_S_ACC, ST_S_UPD,
        ST_Q_INIT, ST_Q_STEP, ST_FIN
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_ACCEPT, OP_INIT_WR, OP_LCG, OP_DLOAD, OP_DSTEP,
        OP_RD_I, OP_RD_J, OP_WR_I, OP_WR_J,
        OP_MUL_X, OP_MUL_Y, OP_FADE1, OP_FADE2, OP_FADE3,
        OP_RD_A, OP_RD_B, OP_RD_AA, OP_RD_BA, OP_RD_AB, OP_RD_BB, OP_LAT_LAST,
        OP_BL_1D, OP_BL_R0, OP_BL_R1, OP_BL_N, OP_ACC, OP_UPD,
        OP_QINIT, OP_QSTEP, OP_FIN
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] idx;
        logic             sel_y;
    } t_cmd;

    typedef struct packed {
        logic             dims_1d;
        logic [OCT_W-1:0] octaves;
        logic             out_free;
    } t_status;

endpackage

@@ hdl/spon_ram.sv @@
// Generic single write port RAM with registered read
module spon_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ hdl/spon_ctrl.sv @@
// Sequencer for reseed shuffle and octave noise sampling
`include "seeded_perlin_octave_noise_unit_assert.svh"
module spon_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_command,
    input  spon_pkg::t_status i_status,
    output logic              o_stall,
    output spon_pkg::t_cmd    o_cmd
);
    import spon_pkg::*;

    localparam int SHUF_STEPS = TAB_AW;
    localparam int QBITS      = 17;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [4:0]       r_step, n_step;
    logic [OCT_W-1:0] r_oct, n_oct;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_step  <= '0;
            r_oct   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_step  <= n_step;
            r_oct   <= n_oct;
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_step  = r_step;
        n_oct   = r_oct;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_oct = '0;
                    n_idx = '0;
                    if (!i_command) begin
                        n_state = ST_R_INIT;
                    end else if (i_status.octaves == '0) begin
                        n_state = ST_FIN;
                    end else begin
                        n_state = ST_S_MX;
                    end
                end
            end
            ST_R_INIT: begin
                if (r_idx == IDX_W'(TABLE_SIZE - 1)) begin
                    n_state = ST_R_LCG;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_R_LCG:   n_state = ST_R_DLOAD;
            ST_R_DLOAD: begin
                n_step  = '0;
                n_state = ST_R_DIV;
            end
            ST_R_DIV: begin
                if (r_step == 5'(SHUF_STEPS - 1)) begin
                    n_state = ST_R_RDI;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_R_RDI: n_state = ST_R_RDJ;
            ST_R_RDJ: n_state = ST_R_WRI;
            ST_R_WRI: n_state = ST_R_WRJ;
            ST_R_WRJ: begin
                if (r_idx == IDX_W'(1)) begin
                    n_state = ST_FIN;
                end else begin
                    n_idx   = r_idx - 1'b1;
                    n_state = ST_R_LCG;
                end
            end
            ST_S_MX:  n_state = i_status.dims_1d ? ST_S_FX1 : ST_S_MY;
            ST_S_MY:  n_state = ST_S_FX1;
            ST_S_FX1: n_state = ST_S_FX2;
            ST_S_FX2: n_state = ST_S_FX3;
            ST_S_FX3: n_state = i_status.dims_1d ? ST_S_RA : ST_S_FY1;
            ST_S_FY1: n_state = ST_S_FY2;
            ST_S_FY2: n_state = ST_S_FY3;
            ST_S_FY3: n_state = ST_S_RA;
            ST_S_RA:  n_state = ST_S_RB;
            ST_S_RB:  n_state = i_status.dims_1d ? ST_S_LAT : ST_S_RAA;
            ST_S_RAA: n_state = ST_S_RBA;
            ST_S_RBA: n_state = ST_S_RAB;
            ST_S_RAB: n_state = ST_S_RBB;
            ST_S_RBB: n_state = ST_S_LAT;
            ST_S_LAT: n_state = i_status.dims_1d ? ST_S_BL1D : ST_S_BLR0;
            ST_S_BL1D: n_state = ST_S_ACC;
            ST_S_BLR0: n_state = ST_S_BLR1;
            ST_S_BLR1: n_state = ST_S_BLN;
            ST_S_BLN:  n_state = ST_S_ACC;
            ST_S_ACC:  n_state = ST_S_UPD;
            ST_S_UPD: begin
                n_oct = r_oct + 1'b1;
                if (OCT_W'(r_oct + 1'b1) == i_status.octaves) begin
                    n_state = ST_Q_INIT;
                end else begin
                    n_state = ST_S_MX;
                end
            end
            ST_Q_INIT: begin
                n_step  = '0;
                n_state = ST_Q_STEP;
            end
            ST_Q_STEP: begin
                if (r_step == 5'(QBITS - 1)) begin
                    n_state = ST_FIN;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_FIN: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_stall     = (r_state != ST_IDLE);
        o_cmd.idx   = r_idx;
        o_cmd.sel_y = (r_state == ST_S_FY1) || (r_state == ST_S_FY2) ||
                      (r_state == ST_S_FY3);
        case (r_state)
            ST_IDLE:    o_cmd.op = i_valid ? OP_ACCEPT : OP_NONE;
            ST_R_INIT:  o_cmd.op = OP_INIT_WR;
            ST_R_LCG:   o_cmd.op = OP_LCG;
            ST_R_DLOAD: o_cmd.op = OP_DLOAD;
            ST_R_DIV:   o_cmd.op = OP_DSTEP;
            ST_R_RDI:   o_cmd.op = OP_RD_I;
            ST_R_RDJ:   o_cmd.op = OP_RD_J;
            ST_R_WRI:   o_cmd.op = OP_WR_I;
            ST_R_WRJ:   o_cmd.op = OP_WR_J;
            ST_S_MX:    o_cmd.op = OP_MUL_X;
            ST_S_MY:    o_cmd.op = OP_MUL_Y;
            ST_S_FX1, ST_S_FY1: o_cmd.op = OP_FADE1;
            ST_S_FX2, ST_S_FY2: o_cmd.op = OP_FADE2;
            ST_S_FX3, ST_S_FY3: o_cmd.op = OP_FADE3;
            ST_S_RA:    o_cmd.op = OP_RD_A;
            ST_S_RB:    o_cmd.op = OP_RD_B;
            ST_S_RAA:   o_cmd.op = OP_RD_AA;
            ST_S_RBA:   o_cmd.op = OP_RD_BA;
            ST_S_RAB:   o_cmd.op = OP_RD_AB;
            ST_S_RBB:   o_cmd.op = OP_RD_BB;
            ST_S_LAT:   o_cmd.op = OP_LAT_LAST;
            ST_S_BL1D:  o_cmd.op = OP_BL_1D;
            ST_S_BLR0:  o_cmd.op = OP_BL_R0;
            ST_S_BLR1:  o_cmd.op = OP_BL_R1;
            ST_S_BLN:   o_cmd.op = OP_BL_N;
            ST_S_ACC:   o_cmd.op = OP_ACC;
            ST_S_UPD:   o_cmd.op = OP_UPD;
            ST_Q_INIT:  o_cmd.op = OP_QINIT;
            ST_Q_STEP:  o_cmd.op = OP_QSTEP;
            ST_FIN:     o_cmd.op = i_status.out_free ? OP_FIN : OP_NONE;
            default:    o_cmd.op = OP_NONE;
        endcase
    end

    `SPON_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_valid && !o_stall,
        r_state != ST_IDLE, "accepted item did not start work")
    `SPON_ASSERT_SAME(a_div_steps, i_clk, i_rst_n, r_state == ST_R_DIV,
        r_step < 5'(SHUF_STEPS), "shuffle divide step out of range")
    `SPON_ASSERT_SAME(a_oct_range, i_clk, i_rst_n, r_state == ST_S_MX,
        r_oct < i_status.octaves, "octave index past octave count")
endmodule

@@ hdl/spon_dp.sv @@
// Datapath: config registers, permutation table, noise arithmetic, result register
`include "seeded_perlin_octave_noise_unit_assert.svh"
module spon_dp #(
    parameter int MAX_OCTAVES     = spon_pkg::MAX_OCTAVES_DEF,
    parameter int COORD_FRAC_BITS = spon_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  spon_pkg::t_cmd     i_cmd,
    output spon_pkg::t_status  o_status,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_wdata,
    input  logic               i_command,
    input  logic signed [31:0] i_x_coord,
    input  logic signed [31:0] i_y_coord,
    input  logic               i_stall,
    output logic               o_valid,
    output logic signed [15:0] o_noise_value,
    output logic               o_reseed_done
);
    import spon_pkg::*;

    localparam int CFB    = COORD_FRAC_BITS;
    localparam int LOG_O  = $clog2(MAX_OCTAVES + 1);
    localparam int ASUM_W = 17 + LOG_O;
    localparam int D_W    = ASUM_W + 1;
    localparam int VAL_W  = 38 + LOG_O;
    localparam int HI_W   = VAL_W - 17;

    function automatic logic signed [19:0] f_grad(input logic [2:0] h,
                                                  input logic signed [19:0] dx,
                                                  input logic signed [19:0] dy);
        logic signed [19:0] v;
        v = h[2] ? dy : dx;
        return h[0] ? -v : v;
    endfunction

    function automatic logic signed [19:0] f_blend(input logic signed [19:0] a,
                                                   input logic signed [19:0] b,
                                                   input logic [17:0] u);
        logic signed [20:0] d;
        logic signed [39:0] p;
        logic signed [20:0] s;
        logic signed [20:0] r;
        d = {b[19], b} - {a[19], a};
        p = $signed({1'b0, u}) * d;
        s = p[36:16];
        r = {a[19], a} + s;
        return r[19:0];
    endfunction

    // configuration
    logic [31:0] r_seed;
    logic [1:0]  r_dims;
    logic [3:0]  r_octc;
    logic [16:0] r_pers;
    logic [15:0] r_lac;

    // item and loop state
    logic               r_cmd;
    logic signed [31:0] r_x, r_y;
    logic [31:0]        r_s;
    logic [7:0]         r_dvd;
    logic [IDX_W-1:0]   r_jrem;
    logic [7:0]         r_ti;
    logic               r_built;
    logic [31:0]        r_freq;
    logic [16:0]        r_amp, r_pers_eff;
    logic signed [VAL_W-1:0] r_val;
    logic [ASUM_W-1:0]  r_asum;
    logic [7:0]         r_ix, r_iy;
    logic [15:0]        r_fx, r_fy;
    logic [31:0]        r_tsq;
    logic [15:0]        r_t3;
    logic [20:0]        r_q16;
    logic [17:0]        r_u, r_v;
    logic [7:0]         r_a, r_b;
    logic [2:0]         r_haa, r_hba, r_hab, r_hbb;
    logic signed [19:0] r_r0, r_r1, r_n;
    logic [HI_W-1:0]    r_rem;
    logic [16:0]        r_nlo, r_qt;
    logic               r_ovf, r_neg;
    logic               r_ovalid, r_oreseed;
    logic signed [15:0] r_onoise;

    // table
    logic              w_we;
    logic [TAB_AW-1:0] w_waddr, w_raddr;
    logic [7:0]        w_wdata, w_rdata, w_pdat;

    spon_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_pdat = r_built ? w_rdata : 8'd0;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = i_cmd.idx[TAB_AW-1:0];
        w_wdata = i_cmd.idx[7:0];
        w_raddr = i_cmd.idx[TAB_AW-1:0];
        case (i_cmd.op)
            OP_INIT_WR: w_we = 1'b1;
            OP_RD_J:    w_raddr = r_jrem[TAB_AW-1:0];
            OP_WR_I: begin
                w_we    = 1'b1;
                w_wdata = w_pdat;
            end
            OP_WR_J: begin
                w_we    = 1'b1;
                w_waddr = r_jrem[TAB_AW-1:0];
                w_wdata = r_ti;
            end
            OP_RD_A:  w_raddr = r_ix;
            OP_RD_B:  w_raddr = r_ix + 8'd1;
            OP_RD_AA: w_raddr = r_a + r_iy;
            OP_RD_BA: w_raddr = r_b + r_iy;
            OP_RD_AB: w_raddr = r_a + r_iy + 8'd1;
            OP_RD_BB: w_raddr = r_b + r_iy + 8'd1;
            default: ;
        endcase
    end

    // status
    logic [OCT_W-1:0] w_octc;
    assign w_octc = OCT_W'(r_octc);
    assign o_status.dims_1d  = (r_dims == 2'd1);
    assign o_status.octaves  = (w_octc > OCT_W'(MAX_OCTAVES)) ? OCT_W'(MAX_OCTAVES) : w_octc;
    assign o_status.out_free = !r_ovalid || !i_stall;

    // coordinate split
    logic signed [31:0] w_coord;
    logic signed [64:0] w_cprod;
    logic [CFB+15:0]    w_ftmp;
    logic [7:0]         w_cell;
    logic [15:0]        w_frac;
    assign w_coord = (i_cmd.op == OP_MUL_Y) ? r_y : r_x;
    assign w_cprod = w_coord * $signed({1'b0, r_freq});
    assign w_cell  = w_cprod[16+CFB+7:16+CFB];
    assign w_ftmp  = {w_cprod[16+CFB-1:16], 16'd0};
    assign w_frac  = w_ftmp[CFB+15:CFB];

    // fade
    logic [15:0] w_t;
    logic [31:0] w_tsq, w_t3p;
    logic [36:0] w_q, w_up;
    assign w_t   = i_cmd.sel_y ? r_fy : r_fx;
    assign w_tsq = w_t * w_t;
    assign w_t3p = r_tsq[31:16] * w_t;
    assign w_q   = 37'({r_tsq, 2'b00}) + 37'({r_tsq, 1'b0}) - 37'({w_t, 20'd0})
                 + 37'({w_t, 16'd0}) + (37'd10 << 32);
    assign w_up  = r_t3 * r_q16;

    // blend
    logic signed [19:0] w_fxs, w_gx, w_fys, w_gy, w_ba, w_bb, w_bres;
    logic [17:0]        w_bu;
    assign w_fxs = $signed({4'h0, r_fx});
    assign w_gx  = $signed({4'hF, r_fx});
    assign w_fys = $signed({4'h0, r_fy});
    assign w_gy  = $signed({4'hF, r_fy});

    always_comb begin
        w_ba = r_r0;
        w_bb = r_r1;
        w_bu = r_v;
        case (i_cmd.op)
            OP_BL_1D: begin
                w_ba = f_grad({2'b00, r_a[0]}, w_fxs, w_fxs);
                w_bb = f_grad({2'b00, r_b[0]}, w_gx, w_gx);
                w_bu = r_u;
            end
            OP_BL_R0: begin
                w_ba = f_grad(r_haa, w_fxs, w_fys);
                w_bb = f_grad(r_hba, w_gx, w_fys);
                w_bu = r_u;
            end
            OP_BL_R1: begin
                w_ba = f_grad(r_hab, w_fxs, w_gy);
                w_bb = f_grad(r_hbb, w_gx, w_gy);
                w_bu = r_u;
            end
            default: ;
        endcase
    end
    assign w_bres = f_blend(w_ba, w_bb, w_bu);

    // accumulate and per octave update
    logic signed [37:0] w_nprod;
    logic [33:0]        w_ampp;
    logic [47:0]        w_frqp;
    assign w_nprod = r_n * $signed({1'b0, r_amp});
    assign w_ampp  = r_amp * r_pers_eff;
    assign w_frqp  = r_freq * r_lac;

    // shuffle remainder step
    logic [IDX_W-1:0] w_jdiv, w_jt;
    logic             w_jge;
    assign w_jdiv = i_cmd.idx + IDX_W'(1);
    assign w_jt   = {r_jrem[7:0], r_dvd[7]};
    assign w_jge  = (w_jt >= w_jdiv);

    // normalize divide
    logic [VAL_W-1:0] w_nmag;
    logic [D_W-1:0]   w_dsr;
    logic [HI_W:0]    w_qt;
    logic             w_qge;
    logic signed [15:0] w_res;
    assign w_nmag = r_val[VAL_W-1] ? VAL_W'(-r_val) : VAL_W'(r_val);
    assign w_dsr  = {r_asum, 1'b0};
    assign w_qt   = {r_rem, r_nlo[16]};
    assign w_qge  = (w_qt >= (HI_W+1)'(w_dsr));

    always_comb begin
        if (r_asum == '0) begin
            w_res = 16'sd0;
        end else if (r_ovf) begin
            w_res = r_neg ? -16'sd32768 : 16'sd32767;
        end else if (r_neg) begin
            w_res = (r_qt > 17'd32768) ? -16'sd32768 : 16'(-$signed({1'b0, r_qt}));
        end else begin
            w_res = (r_qt > 17'd32767) ? 16'sd32767 : $signed(r_qt[15:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed   <= SEED_RST;
            r_dims   <= DIMS_RST;
            r_octc   <= OCTC_RST;
            r_pers   <= PERS_RST;
            r_lac    <= LAC_RST;
            r_built  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SEED: r_seed <= i_cfg_wdata;
                    CFG_DIMS: r_dims <= i_cfg_wdata[1:0];
                    CFG_OCTC: r_octc <= i_cfg_wdata[3:0];
                    CFG_PERS: r_pers <= i_cfg_wdata[16:0];
                    CFG_LAC:  r_lac  <= i_cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (i_cmd.op == OP_INIT_WR) begin
                r_built <= 1'b1;
            end
            if (i_cmd.op == OP_FIN) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_ACCEPT: begin
                r_cmd      <= i_command;
                r_x        <= i_x_coord;
                r_y        <= i_y_coord;
                r_s        <= r_seed;
                r_freq     <= ONE_Q16;
                r_amp      <= ONE_Q16[16:0];
                r_val      <= '0;
                r_asum     <= '0;
                r_pers_eff <= (r_pers > ONE_Q16[16:0]) ? ONE_Q16[16:0] : r_pers;
            end
            OP_LCG:   r_s <= r_s * LCG_MUL + LCG_INC;
            OP_DLOAD: begin
                r_dvd  <= r_s[31:24];
                r_jrem <= '0;
            end
            OP_DSTEP: begin
                r_jrem <= w_jge ? (w_jt - w_jdiv) : w_jt;
                r_dvd  <= {r_dvd[6:0], 1'b0};
            end
            OP_RD_J:  r_ti <= w_pdat;
            OP_MUL_X: begin
                r_ix <= w_cell;
                r_fx <= w_frac;
            end
            OP_MUL_Y: begin
                r_iy <= w_cell;
                r_fy <= w_frac;
            end
            OP_FADE1: r_tsq <= w_tsq;
            OP_FADE2: begin
                r_t3  <= w_t3p[31:16];
                r_q16 <= w_q[36:16];
            end
            OP_FADE3: begin
                if (i_cmd.sel_y) begin
                    r_v <= w_up[33:16];
                end else begin
                    r_u <= w_up[33:16];
                end
            end
            OP_RD_B:  r_a   <= w_pdat;
            OP_RD_AA: r_b   <= w_pdat;
            OP_RD_BA: r_haa <= w_pdat[2:0];
            OP_RD_AB: r_hba <= w_pdat[2:0];
            OP_RD_BB: r_hab <= w_pdat[2:0];
            OP_LAT_LAST: begin
                if (o_status.dims_1d) begin
                    r_b <= w_pdat;
                end else begin
                    r_hbb <= w_pdat[2:0];
                end
            end
            OP_BL_1D, OP_BL_N: r_n  <= w_bres;
            OP_BL_R0:          r_r0 <= w_bres;
            OP_BL_R1:          r_r1 <= w_bres;
            OP_ACC: begin
                r_val  <= r_val + VAL_W'(w_nprod);
                r_asum <= r_asum + ASUM_W'(r_amp);
            end
            OP_UPD: begin
                r_amp  <= w_ampp[32:16];
                r_freq <= w_frqp[39:8];
            end
            OP_QINIT: begin
                r_rem <= w_nmag[VAL_W-1:17];
                r_ovf <= (w_nmag[VAL_W-1:17] >= HI_W'(w_dsr));
                r_nlo <= w_nmag[16:0];
                r_neg <= r_val[VAL_W-1];
                r_qt  <= '0;
            end
            OP_QSTEP: begin
                r_rem <= w_qge ? HI_W'(w_qt - (HI_W+1)'(w_dsr)) : HI_W'(w_qt);
                r_qt  <= {r_qt[15:0], w_qge};
                r_nlo <= {r_nlo[15:0], 1'b0};
            end
            OP_FIN: begin
                r_onoise  <= r_cmd ? w_res : 16'sd0;
                r_oreseed <= !r_cmd;
            end
            default: ;
        endcase
    end

    assign o_valid       = r_ovalid;
    assign o_noise_value = r_onoise;
    assign o_reseed_done = r_oreseed;

    `SPON_ASSERT_SAME(a_swap_range, i_clk, i_rst_n, i_cmd.op == OP_WR_J,
        r_jrem <= i_cmd.idx, "swap partner above shuffle index")
    `SPON_ASSERT_SAME(a_norm_nonzero, i_clk, i_rst_n, i_cmd.op == OP_QINIT,
        r_asum != '0, "normalize with empty amplitude sum")
endmodule

@@ hdl/seeded_perlin_octave_noise_unit.sv @@
// Top level of the seeded Perlin octave noise unit
// Takes one item at a time. A sample (command 1) is accepted, runs the octave
// sequence once per octave in 2D or 1D, is normalized through a 17-step
// restoring divider, and posts its result. A reseed (command 0) fills the
// permutation table with the identity and then shuffles it entry by entry
// (LCG step, 8-step remainder, two reads, two writes). Before the first
// reseed the table reads as all zeros. The result register lets the next
// item be accepted while a finished result waits.
module seeded_perlin_octave_noise_unit #(
    parameter int MAX_OCTAVES     = spon_pkg::MAX_OCTAVES_DEF,
    parameter int COORD_FRAC_BITS = spon_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_command,
    input  logic signed [31:0] i_x_coord,
    input  logic signed [31:0] i_y_coord,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_noise_value,
    output logic               o_reseed_done,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_wdata
);
    import spon_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    spon_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_command (i_command),
        .i_status  (w_status),
        .o_stall   (o_stall),
        .o_cmd     (w_cmd)
    );

    spon_dp #(
        .MAX_OCTAVES     (MAX_OCTAVES),
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_command     (i_command),
        .i_x_coord     (i_x_coord),
        .i_y_coord     (i_y_coord),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_noise_value (o_noise_value),
        .o_reseed_done (o_reseed_done)
    );
endmodule
